// ===== src/cmr_pkg.sv =====
// Package: constants, register indexes, status codes and state type of the CAN reassembler.
`timescale 1ns / 1ps
package cmr_pkg;

	localparam int MAX_PAYLOAD_DEF = 60;
	localparam int FRAME_BYTES     = 8;
	localparam int OVERHEAD        = 4;

	localparam logic [7:0] HEADER_RST      = 8'd115;
	localparam logic [7:0] TAIL_RST        = 8'd101;
	localparam logic [5:0] PAYLOAD_LEN_RST = 6'd8;
	localparam logic [7:0] CRC_POLY_RST    = 8'd49;
	localparam logic [7:0] CRC_INIT_RST    = 8'd255;
	localparam logic       CRC_REFL_RST    = 1'b1;

	typedef enum logic [2:0] {
		CFG_HEADER,
		CFG_TAIL,
		CFG_PAYLOAD_LEN,
		CFG_CRC_POLY,
		CFG_CRC_INIT,
		CFG_CRC_REFL
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IGNORED,
		ST_LEN_MISMATCH,
		ST_ACCUM,
		ST_OVERFLOW,
		ST_TAIL_BAD,
		ST_CRC_BAD,
		ST_DELIVERED,
		ST_RESET
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_WRITE,
		S_POST,
		S_SCAN,
		S_VERDICT,
		S_DRD,
		S_DOUT,
		S_EMIT
	} state_t;

endpackage

// ===== src/can_multiframe_reassembler_core.sv =====
// Top level: CAN multi-frame packet reassembler with CRC-8 check and byte-wise delivery.
//
// Frames enter on the frame channel (frame_valid/frame_ready); results leave on the
// result channel (result_valid/result_ready), one registered output stage.
// One frame is taken at a time. A frame whose bytes are stored passes through a decision
// step, one store-memory write per byte, a count check and an output load before its
// result shows. A frame that completes a packet then scans the store through its single
// read port: reads of the tail, the CRC byte and each payload byte for CRC folding, a
// read drain, a verdict step, then per delivered payload byte a read and an output load.
// A frame whose decision is not to accumulate goes from the decision to the output load;
// an empty frame that opens or continues a packet passes the count check between them.
// frame_ready is high only between items; when the receiver stalls the result
// channel, the block holds the pending result and waits.
// Configuration registers are written through cfg_write/cfg_index/cfg_data at any
// edge with cfg_write high; they are meant to change only while the block is idle.
// Reset (arst_n low) restores register defaults, clears reception and drops any
// pending result. The packet store needs no clearing: a byte is read only after it
// was written in the same packet.
`timescale 1ns / 1ps
module can_multiframe_reassembler_core #(
	parameter int MAX_PAYLOAD = cmr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        frame_valid,
	output logic        frame_ready,
	input  logic        op,
	input  logic [3:0]  frame_len,
	input  logic [63:0] frame_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic [7:0]  payload_byte,
	output logic [5:0]  byte_index,
	output logic        last
);
	import cmr_pkg::*;

	localparam int StoreDepth = MAX_PAYLOAD + OVERHEAD;
	localparam int AW         = $clog2(StoreDepth);
	localparam int CW         = $clog2(StoreDepth + FRAME_BYTES + 1);
	localparam int PW         = (CW > 6) ? CW : 6;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] din,
			input logic [7:0] poly, input logic refl);
		logic [7:0] c;
		logic [7:0] rp;
		c = crc ^ din;
		for (int i = 0; i < 8; i++) begin
			rp[i] = poly[7 - i];
		end
		for (int b = 0; b < 8; b++) begin
			if (refl) begin
				c = c[0] ? ((c >> 1) ^ rp) : (c >> 1);
			end else begin
				c = c[7] ? ((c << 1) ^ poly) : (c << 1);
			end
		end
		return c;
	endfunction

	// configuration registers
	logic [7:0] header_q, tail_cfg_q, crc_poly_q, crc_init_q;
	logic [5:0] payload_len_q;
	logic       crc_refl_q;

	// control and datapath registers
	state_t         state_q, state_d;
	logic           receiving_q;
	logic [CW-1:0]  count_q;
	logic           op_q;
	logic [3:0]     flen_q;
	logic [63:0]    data_q;
	logic [3:0]     wr_i_q;
	logic [CW-1:0]  k_q;
	logic [7:0]     crc_q, tail_q, crc_byte_q;
	status_t        pend_status_q;
	logic           rd_v_s1;
	logic [1:0]     rd_kind_s1;
	logic [7:0]     rdata_s1;

	logic           out_valid_q, out_last_q;
	status_t        out_status_q;
	logic [7:0]     out_byte_q;
	logic [5:0]     out_index_q;

	logic [7:0]     store_mem [StoreDepth];

	// combinational control
	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	logic [7:0]     mem_wdata;
	logic           emit;
	status_t        emit_status;
	logic           emit_last;
	status_t        dec_status;
	logic           slot_free;
	logic [CW-1:0]  plen_w, total_w, eff_count;
	logic           len_too_big, start_ok, overflow, wr_last, scan_issue, dout_last;
	logic [3:0]     flen_in;

	assign slot_free   = !out_valid_q || result_ready;
	assign len_too_big = PW'(payload_len_q) > PW'(MAX_PAYLOAD);
	assign plen_w      = (payload_len_q == 6'd0) ? CW'(1) :
	                     len_too_big ? CW'(MAX_PAYLOAD) : CW'(payload_len_q);
	assign total_w     = CW'(plen_w + CW'(OVERHEAD));
	assign start_ok    = (data_q[7:0] == header_q) && (payload_len_q != 6'd0) &&
	                     !len_too_big && (data_q[15:8] == {2'b00, payload_len_q});
	assign eff_count   = receiving_q ? count_q : '0;
	assign overflow    = CW'(eff_count + CW'(flen_q)) > total_w;
	assign wr_last     = (wr_i_q == 4'(flen_q - 4'd1));
	assign scan_issue  = (k_q <= CW'(plen_w + CW'(1)));
	assign dout_last   = (k_q == CW'(plen_w - CW'(1)));
	assign flen_in     = (frame_len > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : frame_len;

	always_comb begin
		if (op_q) begin
			dec_status = ST_RESET;
		end else if (!receiving_q && data_q[7:0] != header_q) begin
			dec_status = ST_IGNORED;
		end else if (!receiving_q && !start_ok) begin
			dec_status = ST_LEN_MISMATCH;
		end else if (overflow) begin
			dec_status = ST_OVERFLOW;
		end else begin
			dec_status = ST_ACCUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		frame_ready = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = AW'(CW'(count_q + CW'(wr_i_q)));
		mem_wdata   = data_q[{wr_i_q[2:0], 3'b000} +: 8];
		mem_re      = 1'b0;
		mem_raddr   = AW'(k_q);
		emit        = 1'b0;
		emit_status = pend_status_q;
		emit_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				frame_ready = 1'b1;
				if (frame_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (dec_status != ST_ACCUM) begin
					state_d = S_EMIT;
				end else if (flen_q == 4'd0) begin
					state_d = S_POST;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				mem_we = 1'b1;
				if (wr_last) begin
					state_d = S_POST;
				end
			end
			S_POST: begin
				state_d = (count_q != total_w) ? S_EMIT : S_SCAN;
			end
			S_SCAN: begin
				mem_re = scan_issue;
				if (k_q == '0) begin
					mem_raddr = AW'(CW'(total_w - CW'(1)));
				end else if (k_q == CW'(1)) begin
					mem_raddr = AW'(CW'(total_w - CW'(2)));
				end
				if (!scan_issue && !rd_v_s1) begin
					state_d = S_VERDICT;
				end
			end
			S_VERDICT: begin
				if (tail_q != tail_cfg_q || crc_byte_q != crc_q) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_DRD;
				end
			end
			S_DRD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(CW'(k_q + CW'(2)));
				state_d   = S_DOUT;
			end
			S_DOUT: begin
				emit_status = ST_DELIVERED;
				emit_last   = dout_last;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = dout_last ? S_IDLE : S_DRD;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= store_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q      <= HEADER_RST;
			tail_cfg_q    <= TAIL_RST;
			payload_len_q <= PAYLOAD_LEN_RST;
			crc_poly_q    <= CRC_POLY_RST;
			crc_init_q    <= CRC_INIT_RST;
			crc_refl_q    <= CRC_REFL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HEADER:      header_q      <= cfg_data;
				CFG_TAIL:        tail_cfg_q    <= cfg_data;
				CFG_PAYLOAD_LEN: payload_len_q <= cfg_data[5:0];
				CFG_CRC_POLY:    crc_poly_q    <= cfg_data;
				CFG_CRC_INIT:    crc_init_q    <= cfg_data;
				CFG_CRC_REFL:    crc_refl_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			count_q     <= '0;
			rd_v_s1     <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_SCAN) && scan_issue;
			case (state_q)
				S_DECIDE: begin
					if (dec_status == ST_RESET || dec_status == ST_OVERFLOW) begin
						receiving_q <= 1'b0;
						count_q     <= '0;
					end else begin
						receiving_q <= receiving_q || start_ok;
						count_q     <= eff_count;
					end
				end
				S_WRITE: begin
					if (wr_last) begin
						count_q <= CW'(count_q + CW'(flen_q));
					end
				end
				S_POST: begin
					if (count_q == total_w) begin
						receiving_q <= 1'b0;
						count_q     <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= op;
				flen_q <= flen_in;
				data_q <= frame_data;
			end
			S_DECIDE: begin
				wr_i_q        <= '0;
				pend_status_q <= dec_status;
			end
			S_WRITE: begin
				wr_i_q <= wr_i_q + 4'd1;
			end
			S_POST: begin
				pend_status_q <= ST_ACCUM;
				k_q           <= '0;
				crc_q         <= crc_init_q;
			end
			S_SCAN: begin
				if (scan_issue) begin
					k_q        <= CW'(k_q + CW'(1));
					rd_kind_s1 <= (k_q == '0) ? 2'd0 : (k_q == CW'(1)) ? 2'd1 : 2'd2;
				end
				if (rd_v_s1) begin
					case (rd_kind_s1)
						2'd0:    tail_q     <= rdata_s1;
						2'd1:    crc_byte_q <= rdata_s1;
						default: crc_q      <= crc8_step(crc_q, rdata_s1, crc_poly_q, crc_refl_q);
					endcase
				end
			end
			S_VERDICT: begin
				k_q           <= '0;
				pend_status_q <= (tail_q != tail_cfg_q) ? ST_TAIL_BAD : ST_CRC_BAD;
			end
			S_DOUT: begin
				if (slot_free) begin
					k_q <= CW'(k_q + CW'(1));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
			if (emit_status == ST_DELIVERED) begin
				out_byte_q  <= rdata_s1;
				out_index_q <= 6'(k_q);
			end else begin
				out_byte_q  <= '0;
				out_index_q <= '0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign status       = out_status_q;
	assign payload_byte = out_byte_q;
	assign byte_index   = out_index_q;
	assign last         = out_last_q;

endmodule

// ===== src/cmr_checker.sv =====
// Checker: port-level assertions for the CAN reassembler, bound to the top level.
`timescale 1ns / 1ps
module cmr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_valid,
	input logic        frame_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  status,
	input logic [7:0]  payload_byte,
	input logic [5:0]  byte_index,
	input logic        last
);
	import cmr_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status) &&
		$stable(payload_byte) && $stable(byte_index) && $stable(last))
		else $error("stalled result changed");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready |=> !frame_ready)
		else $error("second item taken while one is at work");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_DELIVERED |->
		last && payload_byte == 8'd0 && byte_index == 6'd0)
		else $error("non-delivery result carries payload or is not last");

	a_busy_delivery: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> !frame_ready)
		else $error("item taken during payload delivery");

endmodule

bind can_multiframe_reassembler_core cmr_checker u_cmr_checker (.*);

// ===== bench/reassembly_checker.sv =====
// Checker: mirrors the reassembler state, predicts the results of each item and compares them.
`timescale 1ns / 1ps
module reassembly_checker #(
	parameter int MAX_PAYLOAD = cmr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        frame_valid,
	input  logic        frame_ready,
	input  logic        op,
	input  logic [3:0]  frame_len,
	input  logic [63:0] frame_data,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [2:0]  status,
	input  logic [7:0]  payload_byte,
	input  logic [5:0]  byte_index,
	input  logic        last,
	output int          mismatches,
	output int          outstanding,
	output int          frames_seen,
	output int          results_seen,
	output int          packets_delivered
);
	import cmr_pkg::*;

	localparam int STORE_BYTES = MAX_PAYLOAD + OVERHEAD;

	typedef struct packed {
		status_t    st;
		logic [7:0] data;
		logic [5:0] index;
		logic       fin;
	} rx_result_t;

	rx_result_t due_results [$];

	logic [7:0] hdr_r;
	logic [7:0] tail_r;
	logic [5:0] plen_r;
	logic [7:0] poly_r;
	logic [7:0] init_r;
	logic       refl_r;
	logic       rx_active;
	int         rx_count;
	logic [7:0] pkt_mem [0:STORE_BYTES-1];

	function automatic void queue_status(status_t s);
		rx_result_t r;
		r.st    = s;
		r.data  = 8'h00;
		r.index = 6'd0;
		r.fin   = 1'b1;
		due_results.push_back(r);
	endfunction

	function automatic logic [7:0] crc8_fold(int first, int count);
		logic [7:0] c;
		logic [7:0] rpoly;
		int         i;
		int         b;
		c = init_r;
		for (b = 0; b < 8; b++)
			rpoly[b] = poly_r[7-b];
		for (i = 0; i < count; i++) begin
			c = c ^ pkt_mem[first+i];
			for (b = 0; b < 8; b++) begin
				if (refl_r)
					c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
				else
					c = c[7] ? ((c << 1) ^ poly_r) : (c << 1);
			end
		end
		return c;
	endfunction

	function automatic void reassemble_frame(logic op_i, logic [3:0] len_i, logic [63:0] data_i);
		int         n;
		int         plen;
		int         total;
		int         i;
		rx_result_t r;
		if (op_i == 1'b1) begin
			rx_active = 1'b0;
			rx_count  = 0;
			queue_status(ST_RESET);
			return;
		end
		n = (len_i > FRAME_BYTES) ? FRAME_BYTES : int'(len_i);
		plen = plen_r;
		if (plen < 1)
			plen = 1;
		if (plen > MAX_PAYLOAD)
			plen = MAX_PAYLOAD;
		total = plen + OVERHEAD;
		if (!rx_active) begin
			if (data_i[7:0] != hdr_r) begin
				queue_status(ST_IGNORED);
				return;
			end
			if (plen_r < 1 || plen_r > MAX_PAYLOAD || data_i[15:8] != {2'b00, plen_r}) begin
				queue_status(ST_LEN_MISMATCH);
				return;
			end
			rx_active = 1'b1;
			rx_count  = 0;
		end
		if (rx_count + n > total) begin
			rx_active = 1'b0;
			rx_count  = 0;
			queue_status(ST_OVERFLOW);
			return;
		end
		for (i = 0; i < n; i++)
			pkt_mem[(rx_count + i) % STORE_BYTES] = data_i[8*i +: 8];
		rx_count += n;
		if (rx_count != total) begin
			queue_status(ST_ACCUM);
			return;
		end
		rx_active = 1'b0;
		rx_count  = 0;
		if (pkt_mem[total-1] != tail_r) begin
			queue_status(ST_TAIL_BAD);
			return;
		end
		if (pkt_mem[total-2] != crc8_fold(2, plen)) begin
			queue_status(ST_CRC_BAD);
			return;
		end
		for (i = 0; i < plen; i++) begin
			r.st    = ST_DELIVERED;
			r.data  = pkt_mem[2+i];
			r.index = 6'(i);
			r.fin   = (i + 1 == plen);
			due_results.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rx_result_t want;
		if (!arst_n) begin
			hdr_r             = HEADER_RST;
			tail_r            = TAIL_RST;
			plen_r            = PAYLOAD_LEN_RST;
			poly_r            = CRC_POLY_RST;
			init_r            = CRC_INIT_RST;
			refl_r            = CRC_REFL_RST;
			rx_active         = 1'b0;
			rx_count          = 0;
			due_results.delete();
			mismatches        = 0;
			outstanding       = 0;
			frames_seen       = 0;
			results_seen      = 0;
			packets_delivered = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_HEADER:      hdr_r  = cfg_data;
					CFG_TAIL:        tail_r = cfg_data;
					CFG_PAYLOAD_LEN: plen_r = cfg_data[5:0];
					CFG_CRC_POLY:    poly_r = cfg_data;
					CFG_CRC_INIT:    init_r = cfg_data;
					CFG_CRC_REFL:    refl_r = cfg_data[0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t unexpected item: %0d/%02h/%0d/%b",
							$realtime, status, payload_byte, byte_index, last);
				end else begin
					want = due_results.pop_front();
					if (status !== want.st || payload_byte !== want.data ||
						byte_index !== want.index || last !== want.fin) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t mismatch: want %0d/%02h/%0d/%b got %0d/%02h/%0d/%b",
								$realtime, want.st, want.data, want.index, want.fin,
								status, payload_byte, byte_index, last);
					end else if (want.st == ST_DELIVERED && want.fin) begin
						packets_delivered++;
					end
				end
			end
			if (frame_valid && frame_ready) begin
				frames_seen++;
				reassemble_frame(op, frame_len, frame_data);
			end
			outstanding = due_results.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Testbench top: drives frames and register writes into the reassembler and reports the verdict.
`timescale 1ns / 1ps
module testbench;
	import cmr_pkg::*;

	localparam int PERIOD       = 12;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 360;
	localparam int PHASES       = 8;
	localparam int SETTLE       = 16;
	localparam int DRAIN        = 200;

	localparam logic OP_FRAME     = 1'b0;
	localparam logic OP_LINK_LOST = 1'b1;

	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	typedef enum int {
		FLAW_NONE,
		FLAW_CRC,
		FLAW_TAIL,
		FLAW_OVERRUN,
		FLAW_DROP
	} flaw_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_write    = 1'b0;
	logic [2:0]  cfg_index    = 3'd0;
	logic [7:0]  cfg_data     = 8'd0;
	logic        frame_valid  = 1'b0;
	logic        frame_ready;
	logic        op           = 1'b0;
	logic [3:0]  frame_len    = 4'd0;
	logic [63:0] frame_data   = 64'd0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  payload_byte;
	logic [5:0]  byte_index;
	logic        last;

	int mismatches;
	int outstanding;
	int frames_seen;
	int results_seen;
	int packets_delivered;

	int cycles      = 0;
	int tx_idle_pct = 9;
	int rx_idle_pct = 47;
	int items_done  = 0;
	int settings    = 0;

	logic [7:0] cfg_hdr;
	logic [7:0] cfg_tail;
	logic [5:0] cfg_plen;
	logic [7:0] cfg_poly;
	logic [7:0] cfg_init;
	logic       cfg_refl;
	logic [7:0] pkt_buf [0:71];

	can_multiframe_reassembler_core dut (.*);

	reassembly_checker checker_i (.*);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= rx_idle_pct);

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [7:0] h, logic [7:0] t, logic [7:0] l, logic [7:0] p,
		logic [7:0] i, logic r);
		logic [7:0] rv;
		rv    = 8'($urandom);
		rv[0] = r;
		write_reg(CFG_HEADER, h);
		write_reg(CFG_TAIL, t);
		write_reg(CFG_PAYLOAD_LEN, l);
		write_reg(CFG_CRC_POLY, p);
		write_reg(CFG_CRC_INIT, i);
		write_reg(CFG_CRC_REFL, rv);
		cfg_hdr  = h;
		cfg_tail = t;
		cfg_plen = l[5:0];
		cfg_poly = p;
		cfg_init = i;
		cfg_refl = r;
		settings++;
	endtask

	task automatic send_item(logic op_i, logic [3:0] len_i, logic [63:0] data_i);
		while ($urandom_range(99) < tx_idle_pct) begin
			frame_valid <= 1'b0;
			@(posedge clk);
		end
		frame_valid <= 1'b1;
		op          <= op_i;
		frame_len   <= len_i;
		frame_data  <= data_i;
		@(posedge clk);
		while (!frame_ready)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] payload_crc(int count);
		logic [7:0] c;
		logic [7:0] rpoly;
		int         i;
		int         b;
		c = cfg_init;
		for (b = 0; b < 8; b++)
			rpoly[b] = cfg_poly[7-b];
		for (i = 0; i < count; i++) begin
			c = c ^ pkt_buf[2+i];
			for (b = 0; b < 8; b++) begin
				if (cfg_refl)
					c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
				else
					c = c[7] ? ((c << 1) ^ cfg_poly) : (c << 1);
			end
		end
		return c;
	endfunction

	task automatic send_header(logic [3:0] len_i, logic [7:0] len_byte);
		logic [63:0] d;
		d        = {$urandom, $urandom};
		d[7:0]   = cfg_hdr;
		d[15:8]  = len_byte;
		send_item(OP_FRAME, len_i, d);
		items_done++;
	endtask

	task automatic send_packet(flaw_t flaw, int lead);
		int          plen;
		int          span;
		int          cut;
		int          off;
		int          chunk;
		int          i;
		logic [63:0] d;
		logic [3:0]  lf;
		logic [7:0]  crc;
		plen       = (cfg_plen < 1) ? 1 : int'(cfg_plen);
		pkt_buf[0] = cfg_hdr;
		pkt_buf[1] = {2'b00, cfg_plen};
		for (i = 0; i < plen; i++)
			pkt_buf[2+i] = 8'($urandom);
		crc = payload_crc(plen);
		if (flaw == FLAW_CRC)
			crc = crc ^ 8'($urandom_range(1, 255));
		pkt_buf[plen+2] = crc;
		pkt_buf[plen+3] = cfg_tail;
		if (flaw == FLAW_TAIL)
			pkt_buf[plen+3] = cfg_tail ^ 8'($urandom_range(1, 255));
		span = plen + OVERHEAD;
		if (flaw == FLAW_OVERRUN) begin
			for (i = 0; i < 8; i++)
				pkt_buf[span+i] = 8'($urandom);
			span += $urandom_range(1, 8);
		end
		cut   = (flaw == FLAW_DROP) ? $urandom_range(1, span - 1) : span;
		off   = 0;
		chunk = lead;
		while (off < cut) begin
			if (chunk < 0)
				chunk = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 8);
			if (chunk > cut - off)
				chunk = cut - off;
			for (i = 0; i < 8; i++)
				d[8*i +: 8] = (off + i < span) ? pkt_buf[off+i] : 8'($urandom);
			lf = 4'(chunk);
			if (chunk == 8 && $urandom_range(3) == 0)
				lf = 4'($urandom_range(9, 15));
			send_item(OP_FRAME, lf, d);
			items_done++;
			off  += chunk;
			chunk = -1;
		end
		if (flaw == FLAW_DROP) begin
			send_item(OP_LINK_LOST, 4'($urandom), {$urandom, $urandom});
			items_done++;
		end
	endtask

	initial begin
		int    p;
		int    goal;
		int    pick;
		flaw_t flaw;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_SPARE_LO, 8'($urandom));
		write_reg(CFG_SPARE_HI, 8'($urandom));
		set_config(HEADER_RST, TAIL_RST, {2'b00, PAYLOAD_LEN_RST}, CRC_POLY_RST, CRC_INIT_RST,
			CRC_REFL_RST);
		send_item(OP_LINK_LOST, 4'hF, '1);
		send_item(OP_FRAME, 4'hF, '1);
		send_item(OP_FRAME, 4'h0, '0);
		send_header(4'd8, {2'b00, cfg_plen} ^ 8'h80);
		send_packet(FLAW_NONE, 1);
		send_packet(FLAW_NONE, 0);
		send_packet(FLAW_CRC, -1);
		send_packet(FLAW_TAIL, -1);
		send_packet(FLAW_OVERRUN, -1);
		send_packet(FLAW_DROP, -1);
		send_header(4'd6, {2'b00, cfg_plen});
		wait_idle();
		set_config(cfg_hdr, cfg_tail, 8'h00, cfg_poly, cfg_init, cfg_refl);
		send_item(OP_FRAME, 4'd1, {$urandom, $urandom});
		send_header(4'd8, 8'h00);
		wait_idle();
		set_config(cfg_hdr, cfg_tail, 8'hFF, cfg_poly, cfg_init, cfg_refl);
		send_header(4'd8, 8'd63);
		wait_idle();

		items_done = 0;
		for (p = 0; p < PHASES; p++) begin
			tx_idle_pct = (p < 3) ? 9 : (p < 6) ? 47 : 0;
			rx_idle_pct = (p < 3) ? 47 : (p < 6) ? 9 : 0;
			case (p)
				0: set_config(HEADER_RST, TAIL_RST, {2'b00, PAYLOAD_LEN_RST}, CRC_POLY_RST,
					CRC_INIT_RST, CRC_REFL_RST);
				1: set_config(8'h00, 8'hFF, {2'($urandom), 6'($urandom_range(2, 12))}, 8'h00,
					8'hFF, 1'b0);
				2: set_config(8'hFF, 8'h00, {2'($urandom), 6'd1}, 8'hFF, 8'h00, 1'b1);
				3: set_config(8'($urandom), 8'($urandom), {2'($urandom), 6'd60}, 8'($urandom),
					8'($urandom), 1'b0);
				default: set_config(8'($urandom), 8'($urandom),
					{2'($urandom), 6'($urandom_range(1, 12))}, 8'($urandom), 8'($urandom),
					1'($urandom));
			endcase
			goal = (p + 1) * RANDOM_ITEMS / PHASES;
			while (items_done < goal) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					case ($urandom_range(9))
						0:       flaw = FLAW_CRC;
						1:       flaw = FLAW_TAIL;
						2:       flaw = FLAW_OVERRUN;
						3:       flaw = FLAW_DROP;
						default: flaw = FLAW_NONE;
					endcase
					send_packet(flaw, -1);
				end else if (pick < 80) begin
					send_item(OP_FRAME, 4'($urandom), {$urandom, $urandom});
					items_done++;
				end else if (pick < 88) begin
					send_header(4'($urandom_range(0, 8)),
						{2'b00, cfg_plen} ^ 8'($urandom_range(1, 255)));
				end else if (pick < 94) begin
					send_item(OP_LINK_LOST, 4'($urandom), {$urandom, $urandom});
					items_done++;
				end else begin
					send_item(1'($urandom), 4'($urandom), {$urandom, $urandom});
					items_done++;
				end
			end
			wait_idle();
		end

		repeat (DRAIN) @(posedge clk);
		$display("Run covered %0d frames, %0d results, %0d settings, %0d whole packets.",
			frames_seen, results_seen, settings, packets_delivered);
		$display("Mismatches: %0d, results still awaited: %0d.", mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
